// ----- rtl/lifnes_pkg.sv -----
// Shared types, constants and register codes of the LIF neuron update pipeline.
package lifnes_pkg;

	localparam int unsigned REFRACTORY_STEPS = 20;
	localparam int unsigned INDEX_BITS       = 20;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned IDX_W      = 20;
	localparam int unsigned REFR_W     = 16;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned FRAC_BITS  = 16;

	localparam logic [IDX_W-1:0]  INDEX_MASK  = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);
	localparam logic [REFR_W-1:0] REFR_RELOAD = REFR_W'(REFRACTORY_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_DECAY    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_EX_CURRENT_GAIN  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_IN_CURRENT_GAIN  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_EX_CURRENT_DECAY = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_IN_CURRENT_DECAY = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD        = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_RESET_VOLTAGE    = CFG_IDX_W'(7);

	// register reset values
	localparam logic [DATA_W-1:0] RST_BIAS_GAIN        = 32'd0;
	localparam logic [DATA_W-1:0] RST_VOLTAGE_DECAY    = 32'd65536;
	localparam logic [DATA_W-1:0] RST_EX_CURRENT_GAIN  = 32'd0;
	localparam logic [DATA_W-1:0] RST_IN_CURRENT_GAIN  = 32'd0;
	localparam logic [DATA_W-1:0] RST_EX_CURRENT_DECAY = 32'd65536;
	localparam logic [DATA_W-1:0] RST_IN_CURRENT_DECAY = 32'd65536;
	localparam logic [DATA_W-1:0] RST_THRESHOLD        = 32'd983040;
	localparam logic [DATA_W-1:0] RST_RESET_VOLTAGE    = 32'd0;

	typedef struct packed {
		logic        [IDX_W-1:0]  neuron_index;
		logic signed [DATA_W-1:0] ex_spike_weight;
		logic signed [DATA_W-1:0] in_spike_weight;
		logic signed [DATA_W-1:0] bias_current;
		logic signed [DATA_W-1:0] ex_current;
		logic signed [DATA_W-1:0] in_current;
		logic        [REFR_W-1:0] refractory_left;
		logic signed [DATA_W-1:0] membrane_voltage;
		logic                     last_item;
	} in_item_t;

	typedef struct packed {
		logic        [IDX_W-1:0]  neuron_index_out;
		logic signed [DATA_W-1:0] ex_current_next;
		logic signed [DATA_W-1:0] in_current_next;
		logic        [REFR_W-1:0] refractory_next;
		logic signed [DATA_W-1:0] voltage_next;
		logic                     spiked;
		logic                     last_out;
	} out_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] bias_gain;
		logic signed [DATA_W-1:0] voltage_decay;
		logic signed [DATA_W-1:0] ex_current_gain;
		logic signed [DATA_W-1:0] in_current_gain;
		logic signed [DATA_W-1:0] ex_current_decay;
		logic signed [DATA_W-1:0] in_current_decay;
		logic signed [DATA_W-1:0] threshold;
		logic signed [DATA_W-1:0] reset_voltage;
	} cfg_t;

	// fields common to the stage 1, 2 and 3 payloads
	typedef struct packed {
		logic        [IDX_W-1:0]  idx;
		logic signed [DATA_W-1:0] v;
		logic                     refr;
		logic        [REFR_W-1:0] refr_dec;
		logic                     last;
	} side_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] prod_v;
		logic signed [DATA_W-1:0] prod_ex_v;
		logic signed [DATA_W-1:0] prod_in_v;
		logic signed [DATA_W-1:0] prod_bias;
		logic signed [DATA_W-1:0] prod_ex_c;
		logic signed [DATA_W-1:0] prod_in_c;
		logic signed [DATA_W-1:0] wex;
		logic signed [DATA_W-1:0] win;
		side_t                    side;
	} s1_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] part_a;
		logic signed [DATA_W-1:0] part_b;
		logic signed [DATA_W-1:0] iex_next;
		logic signed [DATA_W-1:0] iin_next;
		side_t                    side;
	} s2_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] nv;
		logic signed [DATA_W-1:0] iex_next;
		logic signed [DATA_W-1:0] iin_next;
		side_t                    side;
	} s3_t;

	// Q16.16 product: floor shift by the fraction bits, keep 32 bits
	function automatic logic signed [DATA_W-1:0] qmul(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [2*DATA_W-1:0] p;
		p = a * b;
		return p[FRAC_BITS +: DATA_W];
	endfunction

endpackage

// ----- rtl/lifnes_if.sv -----
// Channel interfaces: neuron items in, result items out, configuration writes.
interface lifnes_in_if;
	logic                 valid;
	logic                 ready;
	lifnes_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lifnes_out_if;
	logic                  valid;
	logic                  ready;
	lifnes_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lifnes_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [lifnes_pkg::CFG_IDX_W-1:0]      index;
	logic [lifnes_pkg::DATA_W-1:0]         wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/lif_neuron_exp_synapse_update.sv -----
// Top level of the leaky integrate-and-fire neuron update with exponential synapses.
//
// Usage:
//   neuron : one item per neuron - its index, voltage, both synaptic currents,
//            refractory count, bias current, the spike weights of this step and
//            the end-of-batch mark. Accepted when valid and ready are both high.
//   result : one item per accepted neuron, in order - the neuron's next state,
//            its spike flag and the copied end-of-batch mark.
//   cfg    : register writes (index, wdata), always ready; indexes 8 and up are
//            dropped. Write only while the pipeline is empty.
// Timing: four register stages (products, partial sums, final sum, threshold
//   and output register). Throughput is one item per cycle while result.ready
//   stays high; the first stage holds the 32x32 multipliers.
// Reset: all stage valid bits clear, configuration registers take their reset values.
// Stall: when result.ready is low each stage holds its item; bubbles close up,
//   so neuron.ready falls only once all four stages are full. Nothing is dropped
//   or repeated.
module lif_neuron_exp_synapse_update (
	input  logic               clk,
	input  logic               arst_n,
	lifnes_in_if.sink          neuron,
	lifnes_out_if.source       result,
	lifnes_cfg_if.sink         cfg
);

	lifnes_pkg::cfg_t regs;

	logic            valid_s1;
	lifnes_pkg::s1_t data_s1;
	logic            ready_s1;
	logic            valid_s3;
	lifnes_pkg::s3_t data_s3;
	logic            ready_s3;

	// configuration port never back-pressures
	assign cfg.ready = 1'b1;

	lifnes_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.regs     (regs)
	);

	lifnes_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.in_valid (neuron.valid),
		.in_data  (neuron.data),
		.in_ready (neuron.ready),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.ready_dn (ready_s1)
	);

	lifnes_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.ready_s1 (ready_s1),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.ready_dn (ready_s3)
	);

	// output register sits in the last stage
	lifnes_fire u_fire (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.ready_s3 (ready_s3),
		.valid_s4 (result.valid),
		.data_s4  (result.data),
		.ready_dn (result.ready)
	);

endmodule

// ----- rtl/lifnes_cfg.sv -----
// Configuration register bank of the neuron update pipeline.
module lifnes_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [lifnes_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [lifnes_pkg::DATA_W-1:0]    wr_data,
	output lifnes_pkg::cfg_t                 regs
);

	lifnes_pkg::cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bias_gain        <= lifnes_pkg::RST_BIAS_GAIN;
			regs_q.voltage_decay    <= lifnes_pkg::RST_VOLTAGE_DECAY;
			regs_q.ex_current_gain  <= lifnes_pkg::RST_EX_CURRENT_GAIN;
			regs_q.in_current_gain  <= lifnes_pkg::RST_IN_CURRENT_GAIN;
			regs_q.ex_current_decay <= lifnes_pkg::RST_EX_CURRENT_DECAY;
			regs_q.in_current_decay <= lifnes_pkg::RST_IN_CURRENT_DECAY;
			regs_q.threshold        <= lifnes_pkg::RST_THRESHOLD;
			regs_q.reset_voltage    <= lifnes_pkg::RST_RESET_VOLTAGE;
		end else if (wr_en) begin
			case (wr_index)
				lifnes_pkg::REG_BIAS_GAIN:        regs_q.bias_gain        <= wr_data;
				lifnes_pkg::REG_VOLTAGE_DECAY:    regs_q.voltage_decay    <= wr_data;
				lifnes_pkg::REG_EX_CURRENT_GAIN:  regs_q.ex_current_gain  <= wr_data;
				lifnes_pkg::REG_IN_CURRENT_GAIN:  regs_q.in_current_gain  <= wr_data;
				lifnes_pkg::REG_EX_CURRENT_DECAY: regs_q.ex_current_decay <= wr_data;
				lifnes_pkg::REG_IN_CURRENT_DECAY: regs_q.in_current_decay <= wr_data;
				lifnes_pkg::REG_THRESHOLD:        regs_q.threshold        <= wr_data;
				lifnes_pkg::REG_RESET_VOLTAGE:    regs_q.reset_voltage    <= wr_data;
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- rtl/lifnes_mul.sv -----
// Stage 1: the six Q16.16 products and the refractory decode.
module lifnes_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lifnes_pkg::cfg_t     regs,
	input  logic                 in_valid,
	input  lifnes_pkg::in_item_t in_data,
	output logic                 in_ready,
	output logic                 valid_s1,
	output lifnes_pkg::s1_t      data_s1,
	input  logic                 ready_dn
);

	assign in_ready = !valid_s1 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.prod_v    <= lifnes_pkg::qmul(in_data.membrane_voltage, regs.voltage_decay);
			data_s1.prod_ex_v <= lifnes_pkg::qmul(in_data.ex_current, regs.ex_current_gain);
			data_s1.prod_in_v <= lifnes_pkg::qmul(in_data.in_current, regs.in_current_gain);
			data_s1.prod_bias <= lifnes_pkg::qmul(in_data.bias_current, regs.bias_gain);
			data_s1.prod_ex_c <= lifnes_pkg::qmul(in_data.ex_current, regs.ex_current_decay);
			data_s1.prod_in_c <= lifnes_pkg::qmul(in_data.in_current, regs.in_current_decay);
			data_s1.wex       <= in_data.ex_spike_weight;
			data_s1.win       <= in_data.in_spike_weight;
			data_s1.side.idx  <= in_data.neuron_index & lifnes_pkg::INDEX_MASK;
			data_s1.side.v    <= in_data.membrane_voltage;
			data_s1.side.refr <= (in_data.refractory_left != '0);
			data_s1.side.refr_dec <= in_data.refractory_left - lifnes_pkg::REFR_W'(1);
			data_s1.side.last <= in_data.last_item;
		end
	end

endmodule

// ----- rtl/lifnes_sum.sv -----
// Stages 2 and 3: current updates and the wrapping four-term voltage sum.
module lifnes_sum (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  lifnes_pkg::s1_t data_s1,
	output logic            ready_s1,
	output logic            valid_s3,
	output lifnes_pkg::s3_t data_s3,
	input  logic            ready_dn
);

	logic            valid_s2;
	lifnes_pkg::s2_t data_s2;
	logic            ready_s2;

	assign ready_s2 = !valid_s3 || ready_dn;
	assign ready_s1 = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage 2: two partial voltage sums, both currents finished
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			data_s2.part_a   <= data_s1.prod_v + data_s1.prod_ex_v;
			data_s2.part_b   <= data_s1.prod_in_v + data_s1.prod_bias;
			data_s2.iex_next <= data_s1.prod_ex_c + data_s1.wex;
			data_s2.iin_next <= data_s1.prod_in_c + data_s1.win;
			data_s2.side     <= data_s1.side;
		end
	end

	// stage 3: close the voltage sum
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s2) begin
			data_s3.nv       <= data_s2.part_a + data_s2.part_b;
			data_s3.iex_next <= data_s2.iex_next;
			data_s3.iin_next <= data_s2.iin_next;
			data_s3.side     <= data_s2.side;
		end
	end

endmodule

// ----- rtl/lifnes_fire.sv -----
// Stage 4: threshold test, spike reset, refractory count and output register.
module lifnes_fire (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lifnes_pkg::cfg_t      regs,
	input  logic                  valid_s3,
	input  lifnes_pkg::s3_t       data_s3,
	output logic                  ready_s3,
	output logic                  valid_s4,
	output lifnes_pkg::out_item_t data_s4,
	input  logic                  ready_dn
);

	logic fire;

	assign ready_s3 = !valid_s4 || ready_dn;
	assign fire     = !data_s3.side.refr && (data_s3.nv >= regs.threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s3) begin
			data_s4.neuron_index_out <= data_s3.side.idx;
			data_s4.ex_current_next  <= data_s3.iex_next;
			data_s4.in_current_next  <= data_s3.iin_next;
			data_s4.spiked           <= fire;
			data_s4.last_out         <= data_s3.side.last;
			if (data_s3.side.refr) begin
				data_s4.voltage_next    <= data_s3.side.v;
				data_s4.refractory_next <= data_s3.side.refr_dec;
			end else if (fire) begin
				data_s4.voltage_next    <= regs.reset_voltage;
				data_s4.refractory_next <= lifnes_pkg::REFR_RELOAD;
			end else begin
				data_s4.voltage_next    <= data_s3.nv;
				data_s4.refractory_next <= '0;
			end
		end
	end

endmodule
